>>> src/assert_macros.svh
// assertion macros shared by the deframer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clk edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> src/rfd_pkg.sv
// types, codes and constants of the radio frame deframer
package rfd_pkg;

    localparam int unsigned CountW = 9;

    localparam logic [CountW-1:0] HdrBytes  = 9'd7;
    localparam logic [CountW-1:0] PayFirst  = 9'd9;
    localparam logic [CountW-1:0] MinFrame  = 9'd12;
    localparam logic [CountW-1:0] CountMax  = 9'd511;

    localparam logic [CountW-1:0] PosStart  = 9'd0;
    localparam logic [CountW-1:0] PosLength = 9'd1;
    localparam logic [CountW-1:0] PosCompl  = 9'd2;
    localparam logic [CountW-1:0] PosRecv   = 9'd3;
    localparam logic [CountW-1:0] PosEmit   = 9'd4;
    localparam logic [CountW-1:0] PosFunc   = 9'd5;
    localparam logic [CountW-1:0] PosSeq    = 9'd6;
    localparam logic [CountW-1:0] PosHchkHi = 9'd7;
    localparam logic [CountW-1:0] PosHchkLo = 9'd8;

    localparam logic [7:0] CheckMark = 8'h50;
    localparam logic [7:0] LowNibble = 8'h0F;
    localparam logic [7:0] HighNibble = 8'hF0;

    localparam logic [7:0] StartByteReset  = 8'd1;
    localparam logic [7:0] EndByteReset    = 8'd4;
    localparam logic [7:0] OwnAddressReset = 8'd0;

    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CfgStartByte  = 2'd0;
    localparam cfg_idx_t CfgEndByte    = 2'd1;
    localparam cfg_idx_t CfgOwnAddress = 2'd2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_LENGTH    = 3'd1,
        ST_CORRUPT   = 3'd2,
        ST_HDR_CHECK = 3'd3,
        ST_PAY_CHECK = 3'd4,
        ST_ADDRESS   = 3'd5
    } status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
        logic [7:0] own_address;
    } cfg_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       burst_end;
    } beat_t;

    typedef struct packed {
        kind_t      result_kind;
        logic [7:0] payload_byte;
        status_t    frame_status;
        logic [7:0] receiver_addr;
        logic [7:0] emitter_addr;
        logic [7:0] function_id;
        logic [7:0] sequence_id;
        logic [7:0] payload_count;
    } result_t;

    // check word of two bytes, high nibble in upper byte
    function automatic logic [15:0] check_word(input logic [7:0] v);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = CheckMark | ((v & HighNibble) >> 4);
        lo = CheckMark | (v & LowNibble);
        return {hi, lo};
    endfunction

endpackage

>>> src/rfd_in_stage.sv
// input register of the deframer: holds one received beat
module rfd_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // rx_byte
    input  logic          s_tlast,   // burst_end
    input  logic          advance,
    output logic          beat_valid,
    output rfd_pkg::beat_t beat
);

    logic           valid_reg;
    logic           valid_next;
    rfd_pkg::beat_t beat_reg;

    assign s_tready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            beat_reg.rx_byte   <= s_tdata;
            beat_reg.burst_end <= s_tlast;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

>>> src/rfd_checker.sv
// frame state and per-byte checks of the deframer
`include "assert_macros.svh"

module rfd_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  rfd_pkg::cfg_t    cfg,
    input  logic             beat_valid,
    input  rfd_pkg::beat_t   beat,
    input  logic             advance,
    output logic             res_valid,
    output rfd_pkg::result_t res
);

    logic [rfd_pkg::CountW-1:0] count_reg, count_next;
    logic        start_ok_reg, start_ok_next;
    logic [7:0]  length_reg, length_next;
    logic        compl_ok_reg, compl_ok_next;
    logic [7:0]  recv_reg, recv_next;
    logic [7:0]  emit_reg, emit_next;
    logic [7:0]  func_reg, func_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  hxor_reg, hxor_next;
    logic [15:0] hchk_reg, hchk_next;
    logic [7:0]  pxor_reg, pxor_next;
    logic [7:0]  recent0_reg, recent0_next;
    logic [7:0]  recent1_reg, recent1_next;
    logic [7:0]  recent2_reg, recent2_next;

    // fields after this byte is taken in, used by the closing status
    logic        start_ok_u, compl_ok_u;
    logic [7:0]  length_u, recv_u, emit_u, func_u, seq_u, hxor_u;
    logic [15:0] hchk_u;
    logic [rfd_pkg::CountW-1:0] total;
    logic [15:0] pay_rx;
    logic        emit_payload;
    logic [7:0]  b;
    rfd_pkg::status_t st;

    assign b = beat.rx_byte;

    always_comb
    begin
        start_ok_u = start_ok_reg;
        compl_ok_u = compl_ok_reg;
        length_u   = length_reg;
        recv_u     = recv_reg;
        emit_u     = emit_reg;
        func_u     = func_reg;
        seq_u      = seq_reg;
        hchk_u     = hchk_reg;
        hxor_u     = (count_reg < rfd_pkg::HdrBytes) ? (hxor_reg ^ b) : hxor_reg;
        case (count_reg)
            rfd_pkg::PosStart:  start_ok_u = (b == cfg.start_byte);
            rfd_pkg::PosLength: length_u   = b;
            rfd_pkg::PosCompl:  compl_ok_u = (b == ~length_reg);
            rfd_pkg::PosRecv:   recv_u     = b;
            rfd_pkg::PosEmit:   emit_u     = b;
            rfd_pkg::PosFunc:   func_u     = b;
            rfd_pkg::PosSeq:    seq_u      = b;
            rfd_pkg::PosHchkHi: hchk_u     = {b, 8'h00};
            rfd_pkg::PosHchkLo: hchk_u     = {hchk_reg[15:8], b};
            default:            hchk_u     = hchk_reg;
        endcase
    end

    assign total  = (count_reg != rfd_pkg::CountMax) ? (count_reg + 9'd1) : rfd_pkg::CountMax;
    assign pay_rx = {recent0_reg, recent1_reg};
    // payload runs two bytes behind, clear of the trailer
    assign emit_payload = !beat.burst_end && (count_reg >= (rfd_pkg::PayFirst + 9'd2));

    always_comb
    begin
        if (total < rfd_pkg::MinFrame)
        begin
            st = rfd_pkg::ST_LENGTH;
        end
        else if (!start_ok_u || (b != cfg.end_byte) || !compl_ok_u)
        begin
            st = rfd_pkg::ST_CORRUPT;
        end
        else if (total[8] || (length_u != total[7:0]))
        begin
            st = rfd_pkg::ST_LENGTH;
        end
        else if (hchk_u != rfd_pkg::check_word(hxor_u))
        begin
            st = rfd_pkg::ST_HDR_CHECK;
        end
        else if (pay_rx != rfd_pkg::check_word(pxor_reg))
        begin
            st = rfd_pkg::ST_PAY_CHECK;
        end
        else if (recv_u != cfg.own_address)
        begin
            st = rfd_pkg::ST_ADDRESS;
        end
        else
        begin
            st = rfd_pkg::ST_OK;
        end
    end

    always_comb
    begin
        res = '0;
        res.result_kind  = rfd_pkg::KIND_PAYLOAD;
        res.frame_status = rfd_pkg::ST_OK;
        if (beat.burst_end)
        begin
            res.result_kind   = rfd_pkg::KIND_STATUS;
            res.frame_status  = st;
            res.receiver_addr = recv_u;
            res.emitter_addr  = emit_u;
            res.function_id   = func_u;
            res.sequence_id   = seq_u;
            if (!total[8] && (total >= rfd_pkg::MinFrame))
            begin
                res.payload_count = total[7:0] - rfd_pkg::MinFrame[7:0];
            end
        end
        else
        begin
            res.payload_byte = recent1_reg;
        end
    end

    assign res_valid = beat_valid && (beat.burst_end || emit_payload);

    always_comb
    begin
        count_next    = count_reg;
        start_ok_next = start_ok_reg;
        length_next   = length_reg;
        compl_ok_next = compl_ok_reg;
        recv_next     = recv_reg;
        emit_next     = emit_reg;
        func_next     = func_reg;
        seq_next      = seq_reg;
        hxor_next     = hxor_reg;
        hchk_next     = hchk_reg;
        pxor_next     = pxor_reg;
        recent0_next  = recent0_reg;
        recent1_next  = recent1_reg;
        recent2_next  = recent2_reg;
        if (advance)
        begin
            if (beat.burst_end)
            begin
                count_next    = '0;
                start_ok_next = 1'b0;
                length_next   = '0;
                compl_ok_next = 1'b0;
                recv_next     = '0;
                emit_next     = '0;
                func_next     = '0;
                seq_next      = '0;
                hxor_next     = '0;
                hchk_next     = '0;
                pxor_next     = '0;
                recent0_next  = '0;
                recent1_next  = '0;
                recent2_next  = '0;
            end
            else
            begin
                start_ok_next = start_ok_u;
                length_next   = length_u;
                compl_ok_next = compl_ok_u;
                recv_next     = recv_u;
                emit_next     = emit_u;
                func_next     = func_u;
                seq_next      = seq_u;
                hxor_next     = hxor_u;
                hchk_next     = hchk_u;
                if (emit_payload)
                begin
                    pxor_next = pxor_reg ^ recent1_reg;
                end
                recent2_next = recent1_reg;
                recent1_next = recent0_reg;
                recent0_next = b;
                if (count_reg != rfd_pkg::CountMax)
                begin
                    count_next = count_reg + 9'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            start_ok_reg <= 1'b0;
            length_reg   <= '0;
            compl_ok_reg <= 1'b0;
            recv_reg     <= '0;
            emit_reg     <= '0;
            func_reg     <= '0;
            seq_reg      <= '0;
            hxor_reg     <= '0;
            hchk_reg     <= '0;
            pxor_reg     <= '0;
            recent0_reg  <= '0;
            recent1_reg  <= '0;
            recent2_reg  <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            start_ok_reg <= start_ok_next;
            length_reg   <= length_next;
            compl_ok_reg <= compl_ok_next;
            recv_reg     <= recv_next;
            emit_reg     <= emit_next;
            func_reg     <= func_next;
            seq_reg      <= seq_next;
            hxor_reg     <= hxor_next;
            hchk_reg     <= hchk_next;
            pxor_reg     <= pxor_next;
            recent0_reg  <= recent0_next;
            recent1_reg  <= recent1_next;
            recent2_reg  <= recent2_next;
        end
    end

    `ASSERT_CLK(a_clear_after_status, advance && beat.burst_end |=> count_reg == '0,
        "frame state not cleared after status beat")
    `ASSERT_NEVER(a_early_payload,
        res_valid && (res.result_kind == rfd_pkg::KIND_PAYLOAD) && (count_reg < 9'd11),
        "payload beat before the header is complete")
    `ASSERT_NEVER(a_short_count,
        res_valid && (res.result_kind == rfd_pkg::KIND_STATUS) && (res.payload_count != 8'd0)
            && (res.frame_status == rfd_pkg::ST_LENGTH) && !total[8] && (length_u == total[7:0]),
        "length error reported on a frame whose length matches")

endmodule

>>> src/rfd_out_stage.sv
// result register of the deframer, packs the output beat
`include "assert_macros.svh"

module rfd_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  rfd_pkg::result_t res,
    output logic             can_load,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [55:0]      m_tdata,  // payload_byte, frame_status, receiver_addr,
                                       // emitter_addr, function_id, sequence_id,
                                       // payload_count, zero fill
    output logic             m_tuser   // result_kind
);

    logic             valid_reg;
    logic             valid_next;
    rfd_pkg::result_t res_reg;

    assign can_load = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.result_kind;
    assign m_tdata  = {5'd0, res_reg.payload_count, res_reg.sequence_id,
                       res_reg.function_id, res_reg.emitter_addr, res_reg.receiver_addr,
                       res_reg.frame_status, res_reg.payload_byte};

    `ASSERT_NEVER(a_load_when_full, load && valid_reg && !m_tready,
        "result loaded over a beat not yet taken")
    `ASSERT_NEVER(a_status_payload_zero,
        valid_reg && (res_reg.result_kind == rfd_pkg::KIND_STATUS)
            && (res_reg.payload_byte != 8'd0),
        "status beat carries a payload byte")

endmodule

>>> src/radio_frame_deframer.sv
// top level of the radio frame deframer
// usage:
//   s_* carries received bytes, one per beat, tlast on the final byte of a burst.
//   m_* carries results: tuser 0 is a payload byte, tuser 1 the frame status
//   with the header fields and the payload count.
//   cfg_we/cfg_index/cfg_data write start byte, end byte and own address;
//   write only while no frame is in flight.
// path: an accepted byte is held in the input register, and its result is
//   loaded from there into the output register, which drives m_*. payload
//   bytes trail the input by two bytes, since the last two bytes before
//   the end byte are the payload check.
// throughput: one byte per cycle while m_* does not stall; all checks are
//   running xors and compares between the input register and the result register.
// reset: registers return to start byte 1, end byte 4, own address 0; frame
//   state is cleared and both registers are empty.
// stall: the output register holds its beat while m_tready is low; a byte
//   that yields no result still passes, one that does waits and s_tready
//   drops until the output register frees up.
module radio_frame_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    input  logic        s_tlast,   // burst_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // payload_byte[7:0], frame_status[10:8],
                                   // receiver_addr[18:11], emitter_addr[26:19],
                                   // function_id[34:27], sequence_id[42:35],
                                   // payload_count[50:43], zero fill
    output logic        m_tuser,   // result_kind
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    rfd_pkg::cfg_t    cfg_reg;
    rfd_pkg::cfg_t    cfg_next;
    rfd_pkg::beat_t   beat;
    rfd_pkg::result_t res;
    logic             beat_valid;
    logic             res_valid;
    logic             can_load;
    logic             advance;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                rfd_pkg::CfgStartByte:  cfg_next.start_byte  = cfg_data;
                rfd_pkg::CfgEndByte:    cfg_next.end_byte    = cfg_data;
                rfd_pkg::CfgOwnAddress: cfg_next.own_address = cfg_data;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte  <= rfd_pkg::StartByteReset;
            cfg_reg.end_byte    <= rfd_pkg::EndByteReset;
            cfg_reg.own_address <= rfd_pkg::OwnAddressReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // a byte moves on unless its result finds the output register full
    assign advance = beat_valid && (!res_valid || can_load);

    rfd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    rfd_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .beat_valid (beat_valid),
        .beat       (beat),
        .advance    (advance),
        .res_valid  (res_valid),
        .res        (res)
    );

    rfd_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && res_valid),
        .res      (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> tb/sv/radio_frame_deframer_test.sv
// self-checking testbench of the radio frame deframer with a byte-level frame predictor
module radio_frame_deframer_test;

    localparam int CycleLimit = 500000;
    localparam int HoldCycles = 300;
    localparam int PhaseBeats = 200;
    localparam rfd_pkg::cfg_idx_t CfgUnused = 2'd3;

    typedef enum int {
        FL_NONE,
        FL_START,
        FL_END,
        FL_COMPL,
        FL_LENGTH,
        FL_HCHECK,
        FL_PCHECK,
        FL_RECV,
        FL_TRUNC,
        FL_FLIP
    } flaw_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;   // rx_byte
    logic        s_tlast = 1'b0;   // burst_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;          // payload_byte, frame_status, receiver_addr, emitter_addr,
                                   // function_id, sequence_id, payload_count, zero fill
    logic        m_tuser;          // result_kind
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [7:0]  cfg_data = 8'd0;

    radio_frame_deframer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // bytes waiting to be sent and results still to come
    rfd_pkg::beat_t   rx_beats[$];
    rfd_pkg::result_t frame_results[$];
    int      queued_beats = 0;
    int      errors = 0;
    int      cycles = 0;
    int      idle_pct = 0;
    int      stall_pct = 0;
    bit      hold_req = 1'b0;
    int      hold_left = 0;
    logic    in_taken = 1'b0;

    // predictor copy of the registers and the frame state
    logic [7:0]  start_cfg = rfd_pkg::StartByteReset;
    logic [7:0]  end_cfg = rfd_pkg::EndByteReset;
    logic [7:0]  addr_cfg = rfd_pkg::OwnAddressReset;
    logic [8:0]  cnt = '0;
    logic        got_start = 1'b0;
    logic        compl_good = 1'b0;
    logic [7:0]  len_byte = '0;
    logic [7:0]  rcv_q = '0;
    logic [7:0]  emt_q = '0;
    logic [7:0]  fn_q = '0;
    logic [7:0]  seq_q = '0;
    logic [7:0]  hdr_sum = '0;
    logic [15:0] hdr_rx = '0;
    logic [7:0]  pay_sum = '0;
    logic [7:0]  tail0 = '0;   // newest byte
    logic [7:0]  tail1 = '0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] nibble_check(input logic [7:0] v);
        return {rfd_pkg::CheckMark | {4'h0, v[7:4]}, rfd_pkg::CheckMark | {4'h0, v[3:0]}};
    endfunction

    function automatic logic [7:0] flip_mask();
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic deframe_byte(input logic [7:0] b, input logic last);
        logic [8:0]        n;
        logic [8:0]        pc;
        rfd_pkg::status_t  st;
        rfd_pkg::result_t  res;
        begin
            res = '0;
            if (cnt < rfd_pkg::HdrBytes)
                hdr_sum ^= b;
            case (cnt)
                rfd_pkg::PosStart:  got_start = (b == start_cfg);
                rfd_pkg::PosLength: len_byte = b;
                rfd_pkg::PosCompl:  compl_good = (b == ~len_byte);
                rfd_pkg::PosRecv:   rcv_q = b;
                rfd_pkg::PosEmit:   emt_q = b;
                rfd_pkg::PosFunc:   fn_q = b;
                rfd_pkg::PosSeq:    seq_q = b;
                rfd_pkg::PosHchkHi: hdr_rx = {b, 8'h00};
                rfd_pkg::PosHchkLo: hdr_rx[7:0] = b;
                default: ;
            endcase
            if (last)
            begin
                n = (cnt < rfd_pkg::CountMax) ? cnt + 9'd1 : rfd_pkg::CountMax;
                if (n < rfd_pkg::MinFrame)
                    st = rfd_pkg::ST_LENGTH;
                else if (!got_start || b != end_cfg)
                    st = rfd_pkg::ST_CORRUPT;
                else if (!compl_good)
                    st = rfd_pkg::ST_CORRUPT;
                else if (n > 9'd255 || {1'b0, len_byte} != n)
                    st = rfd_pkg::ST_LENGTH;
                else if (hdr_rx != nibble_check(hdr_sum))
                    st = rfd_pkg::ST_HDR_CHECK;
                else if ({tail0, tail1} != nibble_check(pay_sum))
                    st = rfd_pkg::ST_PAY_CHECK;
                else if (rcv_q != addr_cfg)
                    st = rfd_pkg::ST_ADDRESS;
                else
                    st = rfd_pkg::ST_OK;
                pc = n - rfd_pkg::MinFrame;
                res.result_kind = rfd_pkg::KIND_STATUS;
                res.frame_status = st;
                res.receiver_addr = rcv_q;
                res.emitter_addr = emt_q;
                res.function_id = fn_q;
                res.sequence_id = seq_q;
                res.payload_count = (n >= rfd_pkg::MinFrame && n <= 9'd255) ? pc[7:0] : 8'd0;
                frame_results.insert(frame_results.size(), res);
                cnt = '0;
                got_start = 1'b0;
                compl_good = 1'b0;
                len_byte = '0;
                rcv_q = '0;
                emt_q = '0;
                fn_q = '0;
                seq_q = '0;
                hdr_sum = '0;
                hdr_rx = '0;
                pay_sum = '0;
                tail0 = '0;
                tail1 = '0;
            end
            else
            begin
                // the two newest bytes may still turn out to be the payload check
                if (cnt >= rfd_pkg::PayFirst + 9'd2)
                begin
                    pay_sum ^= tail1;
                    res.result_kind = rfd_pkg::KIND_PAYLOAD;
                    res.payload_byte = tail1;
                    frame_results.insert(frame_results.size(), res);
                end
                tail1 = tail0;
                tail0 = b;
                if (cnt < rfd_pkg::CountMax)
                    cnt = cnt + 9'd1;
            end
        end
    endtask

    function automatic void queue_byte(input logic [7:0] b, input logic last);
        rfd_pkg::beat_t bt;
        bt.rx_byte = b;
        bt.burst_end = last;
        rx_beats.insert(rx_beats.size(), bt);
        queued_beats++;
    endfunction

    task automatic add_frame(input int plen, input flaw_t flaw);
        logic [7:0]  fb[$];
        logic [7:0]  len_v;
        logic [7:0]  hsum;
        logic [7:0]  psum;
        logic [7:0]  pb;
        logic [15:0] hw;
        logic [15:0] pw;
        int          tot;
        int          cut;
        int          k;
        begin
            tot = plen + 12;
            len_v = (tot > 255) ? 8'hFF : tot[7:0];
            if (flaw == FL_LENGTH)
                len_v ^= flip_mask();
            fb.insert(fb.size(), (flaw == FL_START) ? start_cfg ^ flip_mask() : start_cfg);
            fb.insert(fb.size(), len_v);
            fb.insert(fb.size(), (flaw == FL_COMPL) ? ~len_v ^ flip_mask() : ~len_v);
            fb.insert(fb.size(), (flaw == FL_RECV) ? addr_cfg ^ flip_mask() : addr_cfg);
            repeat (3) fb.insert(fb.size(), 8'($urandom_range(255)));
            hsum = '0;
            for (k = 0; k < 7; k++)
                hsum ^= fb[k];
            hw = nibble_check(hsum);
            if (flaw == FL_HCHECK)
            begin
                k = $urandom_range(15);
                hw[k] = ~hw[k];
            end
            fb.insert(fb.size(), hw[15:8]);
            fb.insert(fb.size(), hw[7:0]);
            psum = '0;
            repeat (plen)
            begin
                pb = 8'($urandom_range(255));
                psum ^= pb;
                fb.insert(fb.size(), pb);
            end
            pw = nibble_check(psum);
            if (flaw == FL_PCHECK)
            begin
                k = $urandom_range(15);
                pw[k] = ~pw[k];
            end
            // payload check goes low byte first
            fb.insert(fb.size(), pw[7:0]);
            fb.insert(fb.size(), pw[15:8]);
            fb.insert(fb.size(), (flaw == FL_END) ? end_cfg ^ flip_mask() : end_cfg);
            if (flaw == FL_FLIP)
            begin
                k = $urandom_range(fb.size() - 1);
                fb[k] ^= flip_mask();
            end
            cut = (flaw == FL_TRUNC) ? $urandom_range(1, 11) : fb.size();
            for (k = 0; k < cut; k++)
                queue_byte(fb[k], k == cut - 1);
        end
    endtask

    task automatic add_noise(input int n);
        int k;
        begin
            for (k = 0; k < n; k++)
                queue_byte(8'($urandom_range(255)), (k == n - 1) || ($urandom_range(5) == 0));
        end
    endtask

    task automatic random_frames(input int target);
        int first;
        int sel;
        int plen;
        begin
            first = queued_beats;
            while (queued_beats - first < target)
            begin
                sel = $urandom_range(99);
                // mostly short payloads, now and then up to the largest
                plen = ($urandom_range(9) == 0) ? $urandom_range(243) : $urandom_range(16);
                if (sel < 55)
                    add_frame(plen, FL_NONE);
                else if (sel < 60)
                    add_frame(plen, FL_START);
                else if (sel < 65)
                    add_frame(plen, FL_END);
                else if (sel < 69)
                    add_frame(plen, FL_COMPL);
                else if (sel < 73)
                    add_frame(plen, FL_LENGTH);
                else if (sel < 78)
                    add_frame(plen, FL_HCHECK);
                else if (sel < 83)
                    add_frame(plen, FL_PCHECK);
                else if (sel < 88)
                    add_frame(plen, FL_RECV);
                else if (sel < 93)
                    add_frame(plen, FL_TRUNC);
                else if (sel < 97)
                    add_noise($urandom_range(1, 20));
                else
                    add_frame(plen, FL_FLIP);
            end
        end
    endtask

    task automatic write_reg(input rfd_pkg::cfg_idx_t idx, input logic [7:0] val);
        begin
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= val;
            @(negedge clk);
            cfg_we <= 1'b0;
            case (idx)
                rfd_pkg::CfgStartByte:  start_cfg = val;
                rfd_pkg::CfgEndByte:    end_cfg = val;
                rfd_pkg::CfgOwnAddress: addr_cfg = val;
                default: ;
            endcase
        end
    endtask

    task automatic drain();
        begin
            while (rx_beats.size() != 0 || s_tvalid || frame_results.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        begin
            if (want != got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        end
    endtask

    // byte sender
    always @(negedge clk)
    begin : sender
        rfd_pkg::beat_t nxt;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_taken)
        begin
            if (rx_beats.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                nxt = rx_beats.pop_front();
                s_tdata <= nxt.rx_byte;
                s_tlast <= nxt.burst_end;
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result receiver, with an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HoldCycles;
            hold_req = 1'b0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin : monitor
        rfd_pkg::result_t want;
        if (!rst_n)
            in_taken = 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (frame_results.size() == 0)
                begin
                    $error("result beat with no expected result");
                    errors++;
                end
                else
                begin
                    want = frame_results.pop_front();
                    check_field("result_kind", want.result_kind, m_tuser);
                    check_field("payload_byte", want.payload_byte, m_tdata[7:0]);
                    check_field("frame_status", want.frame_status, m_tdata[10:8]);
                    check_field("receiver_addr", want.receiver_addr, m_tdata[18:11]);
                    check_field("emitter_addr", want.emitter_addr, m_tdata[26:19]);
                    check_field("function_id", want.function_id, m_tdata[34:27]);
                    check_field("sequence_id", want.sequence_id, m_tdata[42:35]);
                    check_field("payload_count", want.payload_count, m_tdata[50:43]);
                end
            end
            in_taken = s_tvalid && s_tready;
            if (in_taken)
                deframe_byte(s_tdata, s_tlast);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CycleLimit)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin : main
        int p;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset register values: minimal good frame, lone bytes, short burst
        add_frame(0, FL_NONE);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        add_frame(0, FL_TRUNC);
        drain();

        for (p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(rfd_pkg::CfgStartByte, 8'h00);
                    write_reg(rfd_pkg::CfgEndByte, 8'hFF);
                    write_reg(rfd_pkg::CfgOwnAddress, 8'h00);
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    write_reg(rfd_pkg::CfgStartByte, 8'($urandom_range(255)));
                    write_reg(rfd_pkg::CfgEndByte, 8'($urandom_range(255)));
                    write_reg(rfd_pkg::CfgOwnAddress, 8'($urandom_range(255)));
                    write_reg(CfgUnused, 8'($urandom_range(255)));
                    idle_pct = 72;
                    stall_pct = 0;
                end
                2:
                begin
                    write_reg(rfd_pkg::CfgStartByte, 8'hFF);
                    write_reg(rfd_pkg::CfgEndByte, 8'h00);
                    write_reg(rfd_pkg::CfgOwnAddress, 8'hFF);
                    idle_pct = 0;
                    stall_pct = 72;
                end
                default:
                begin
                    write_reg(rfd_pkg::CfgStartByte, 8'($urandom_range(255)));
                    write_reg(rfd_pkg::CfgEndByte, 8'($urandom_range(255)));
                    write_reg(rfd_pkg::CfgOwnAddress, 8'($urandom_range(255)));
                    idle_pct = 23;
                    stall_pct = 23;
                end
            endcase
            if (p == 0)
            begin
                // receiver blocks while bytes keep coming; long burst saturates the count
                hold_req = 1'b1;
                add_frame($urandom_range(500, 520), FL_NONE);
            end
            if (p == 2)
                add_frame($urandom_range(244, 260), FL_NONE);
            random_frames(PhaseBeats);
            drain();
        end

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
